FILE: design/iptcp_pkg.sv
// Shared types and constants for the IPv4/IPv6 + TCP header parser.
// No dependencies; used by iptcp_capture and ip_tcp_header_parser.
`timescale 1ns / 1ps

package iptcp_pkg;

	localparam int unsigned COUNT_W = 16;

	localparam logic [3:0]  IP_VERSION_4     = 4'd4;
	localparam logic [3:0]  IP_VERSION_6     = 4'd6;
	localparam logic [7:0]  TCP_PROTOCOL     = 8'd6;
	localparam logic [5:0]  IPV6_HEADER      = 6'd40;
	localparam logic [15:0] IPV4_MIN_HEADER  = 16'd20;
	localparam logic [15:0] IPV6_MIN_LENGTH  = 16'd40;
	localparam logic [15:0] TCP_MIN_HEADER   = 16'd20;
	localparam logic [5:0]  L3_MIN_HEADER    = 6'd20;

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_TOO_SHORT = 3'd1,
		ST_BAD_IHL   = 3'd2,
		ST_NOT_TCP   = 3'd3,
		ST_NOT_IP    = 3'd4
	} status_t;

	// Header fields gathered so far for the packet in flight.
	typedef struct packed {
		logic [COUNT_W-1:0] count;
		logic [3:0]         version;
		logic [5:0]         l3_bytes;
		logic [7:0]         protocol;
		logic [127:0]       src_addr;
		logic [127:0]       dst_addr;
		logic [31:0]        ports;
		logic [5:0]         l4_bytes;
	} hdr_fields_t;

endpackage

FILE: design/iptcp_capture.sv
// Per-packet header state: byte counter and field capture at fixed offsets and at offsets past the network header.
// Depends on iptcp_pkg. Presents the state as it stands after the current byte.
`timescale 1ns / 1ps

module iptcp_capture #(
	parameter int MAX_PACKET_BYTES = 65535
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      step,
	input  logic [7:0]                data_byte,
	input  logic                      last_byte,
	output iptcp_pkg::hdr_fields_t    fields_nxt
);
	import iptcp_pkg::*;

	localparam logic [COUNT_W-1:0] MAX_COUNT = COUNT_W'(MAX_PACKET_BYTES);

	hdr_fields_t        state_q;
	hdr_fields_t        f;
	logic [COUNT_W-1:0] pos;
	logic [COUNT_W-1:0] l3_ext;
	logic [COUNT_W-1:0] port_off;
	logic               is_v4;
	logic               is_v6;
	logic               src_hit;
	logic               dst_hit;
	logic               port_hit;
	logic [3:0]         src_idx;
	logic [3:0]         dst_idx;
	logic [COUNT_W-1:0] src_rel;
	logic [COUNT_W-1:0] dst_rel;

	always_comb begin
		pos      = state_q.count;
		is_v4    = (state_q.version == IP_VERSION_4);
		is_v6    = (state_q.version == IP_VERSION_6);
		l3_ext   = COUNT_W'(state_q.l3_bytes);
		port_off = pos - l3_ext;

		src_hit = 1'b0;
		dst_hit = 1'b0;
		src_rel = pos;
		dst_rel = pos - COUNT_W'(4);
		if (is_v4) begin
			src_hit = (pos >= COUNT_W'(12)) && (pos < COUNT_W'(16));
			dst_hit = (pos >= COUNT_W'(16)) && (pos < COUNT_W'(20));
		end else if (is_v6) begin
			src_rel = pos - COUNT_W'(8);
			dst_rel = pos - COUNT_W'(24);
			src_hit = (pos >= COUNT_W'(8))  && (pos < COUNT_W'(24));
			dst_hit = (pos >= COUNT_W'(24)) && (pos < COUNT_W'(40));
		end
		src_idx  = src_rel[3:0];
		dst_idx  = dst_rel[3:0];
		port_hit = (state_q.l3_bytes >= L3_MIN_HEADER) && (pos >= l3_ext)
			&& (pos < l3_ext + COUNT_W'(4));
	end

	always_comb begin
		f = state_q;
		if (pos < MAX_COUNT) begin
			f.count = pos + COUNT_W'(1);
			if (pos == '0) begin
				f.version  = data_byte[7:4];
				f.l3_bytes = (data_byte[7:4] == IP_VERSION_6) ? IPV6_HEADER
					: {data_byte[3:0], 2'b00};
			end else if (is_v4 || is_v6) begin
				if ((is_v4 && pos == COUNT_W'(9)) || (is_v6 && pos == COUNT_W'(6)))
					f.protocol = data_byte;
				for (int i = 0; i < 16; i++) begin
					if (src_hit && src_idx == 4'(i))
						f.src_addr[8*(15-i) +: 8] = data_byte;
					if (dst_hit && dst_idx == 4'(i))
						f.dst_addr[8*(15-i) +: 8] = data_byte;
				end
				if (port_hit) begin
					for (int j = 0; j < 4; j++) begin
						if (port_off[1:0] == 2'(j))
							f.ports[8*(3-j) +: 8] = data_byte;
					end
				end else if (state_q.l3_bytes >= L3_MIN_HEADER
					&& pos == l3_ext + COUNT_W'(12)) begin
					f.l4_bytes = {data_byte[7:4], 2'b00};
				end
			end
		end
	end

	assign fields_nxt = f;

	// Clear everything once the last byte of a packet has been taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (step) begin
			state_q <= last_byte ? '0 : f;
		end
	end

endmodule

FILE: design/ip_tcp_header_parser.sv
// IPv4/IPv6 + TCP header parser, one packet byte per request.
// A last byte passes from the input register to the result register.
// Throughput: one byte per cycle unless a last byte waits in the input register
// for an unread result to leave the result slot; set by the single capture/check pass.
// Reset (arst_n low) clears the pipeline valids and all packet state.
`timescale 1ns / 1ps

module ip_tcp_header_parser #(
	parameter int MAX_PACKET_BYTES = 65535
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        byte_valid,
	output logic        byte_ready,
	input  logic [7:0]  data_byte,
	input  logic        last_byte,
	output logic        result_valid,
	input  logic        result_ready,
	output logic [2:0]  status,
	output logic        is_ipv6,
	output logic [63:0] source_high,
	output logic [63:0] source_low,
	output logic [63:0] destination_high,
	output logic [63:0] destination_low,
	output logic [15:0] source_port,
	output logic [15:0] destination_port,
	output logic [5:0]  network_header_bytes,
	output logic [5:0]  transport_header_bytes,
	output logic [6:0]  payload_offset,
	output logic [15:0] payload_bytes
);
	import iptcp_pkg::*;

	logic        valid_s1;
	logic [7:0]  data_s1;
	logic        last_s1;
	logic        advance;
	logic        load_result;

	hdr_fields_t        f;
	status_t            st;
	logic [COUNT_W-1:0] len;
	logic [6:0]         hdr_sum;

	logic        out_valid_q;
	status_t     status_q;
	logic        is_ipv6_q;
	logic [127:0] src_q;
	logic [127:0] dst_q;
	logic [31:0] ports_q;
	logic [5:0]  l3_q;
	logic [5:0]  l4_q;
	logic [6:0]  offset_q;
	logic [15:0] payload_q;

	// A non-last byte always moves on; a last byte needs the result slot.
	assign advance     = valid_s1 && (!last_s1 || !out_valid_q || result_ready);
	assign byte_ready  = !valid_s1 || advance;
	assign load_result = advance && last_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (byte_ready) begin
			valid_s1 <= byte_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (byte_ready && byte_valid) begin
			data_s1 <= data_byte;
			last_s1 <= last_byte;
		end
	end

	iptcp_capture #(
		.MAX_PACKET_BYTES(MAX_PACKET_BYTES)
	) u_capture (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (advance),
		.data_byte  (data_s1),
		.last_byte  (last_s1),
		.fields_nxt (f)
	);

	always_comb begin
		len     = f.count;
		hdr_sum = 7'(f.l3_bytes) + 7'(f.l4_bytes);
		st      = ST_OK;
		if (f.version == IP_VERSION_4) begin
			if (len < IPV4_MIN_HEADER)
				st = ST_TOO_SHORT;
			else if (f.l3_bytes < L3_MIN_HEADER)
				st = ST_BAD_IHL;
			else if (f.protocol != TCP_PROTOCOL)
				st = ST_NOT_TCP;
		end else if (f.version == IP_VERSION_6) begin
			if (len < IPV6_MIN_LENGTH)
				st = ST_TOO_SHORT;
			else if (f.protocol != TCP_PROTOCOL)
				st = ST_NOT_TCP;
		end else begin
			st = ST_NOT_IP;
		end
		if (st == ST_OK && (COUNT_W'(f.l3_bytes) + TCP_MIN_HEADER) > len)
			st = ST_TOO_SHORT;
		if (st == ST_OK && COUNT_W'(hdr_sum) > len)
			st = ST_TOO_SHORT;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_result) begin
			out_valid_q <= 1'b1;
		end else if (result_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Hold everything but status at zero unless the packet parsed cleanly.
	always_ff @(posedge clk) begin
		if (load_result) begin
			status_q <= st;
			if (st == ST_OK) begin
				is_ipv6_q <= (f.version == IP_VERSION_6);
				src_q     <= f.src_addr;
				dst_q     <= f.dst_addr;
				ports_q   <= f.ports;
				l3_q      <= f.l3_bytes;
				l4_q      <= f.l4_bytes;
				offset_q  <= hdr_sum;
				payload_q <= len - COUNT_W'(hdr_sum);
			end else begin
				is_ipv6_q <= 1'b0;
				src_q     <= '0;
				dst_q     <= '0;
				ports_q   <= '0;
				l3_q      <= '0;
				l4_q      <= '0;
				offset_q  <= '0;
				payload_q <= '0;
			end
		end
	end

	assign result_valid           = out_valid_q;
	assign status                 = status_q;
	assign is_ipv6                = is_ipv6_q;
	assign source_high            = src_q[127:64];
	assign source_low             = src_q[63:0];
	assign destination_high       = dst_q[127:64];
	assign destination_low        = dst_q[63:0];
	assign source_port            = ports_q[31:16];
	assign destination_port       = ports_q[15:0];
	assign network_header_bytes   = l3_q;
	assign transport_header_bytes = l4_q;
	assign payload_offset         = offset_q;
	assign payload_bytes          = payload_q;

endmodule
